// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the matcher RTL.
// Expects signals named clk and rst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define NMM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define NMM_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/nmm_pkg.sv =====
// Types and constants for the nearest marker matcher.
// No dependencies; used by every other file of the block but assert_macros.svh.
`default_nettype none

package nmm_pkg;

    localparam int MAX_REFS    = 32;
    localparam int COORD_BITS  = 24;
    localparam int POS_W       = 24;
    localparam int ID_W        = 16;
    localparam int REQ_W       = 2;
    localparam int DIST_W      = 51;

    localparam int IDX_W       = (MAX_REFS > 1) ? $clog2(MAX_REFS) : 1;
    localparam int CNT_W       = $clog2(MAX_REFS + 1);
    localparam int DIFF_W      = COORD_BITS + 1;
    localparam int SQ_W        = 2 * DIFF_W;
    localparam int SUM_W       = (SQ_W + 2 > DIST_W + 1) ? SQ_W + 2 : DIST_W + 1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    typedef enum logic [REQ_W-1:0] {
        OP_LOAD    = 2'd0,
        OP_MEASURE = 2'd1,
        OP_EMIT    = 2'd2,
        OP_CLEAR   = 2'd3
    } op_t;

    typedef struct packed {
        op_t                          op;
        logic [ID_W-1:0]              id;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
    } cmd_t;

endpackage

`default_nettype wire

// ===== hdl/nmm_ifs.sv =====
// Handshake channel interfaces: request channel and result channel.
// Depends on nmm_pkg for field widths.
`default_nettype none

interface nmm_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [nmm_pkg::REQ_W-1:0]            req_type;
    logic [nmm_pkg::ID_W-1:0]             marker_id;
    logic signed [nmm_pkg::POS_W-1:0]     pos_x;
    logic signed [nmm_pkg::POS_W-1:0]     pos_y;
    logic signed [nmm_pkg::POS_W-1:0]     pos_z;

    modport source (output valid, req_type, marker_id, pos_x, pos_y, pos_z, input ready);
    modport sink   (input valid, req_type, marker_id, pos_x, pos_y, pos_z, output ready);
endinterface

interface nmm_res_if;
    logic                      valid;
    logic                      ready;
    logic [nmm_pkg::ID_W-1:0]  stored_id;
    logic [nmm_pkg::ID_W-1:0]  match_id;
    logic                      matched;
    logic                      pair_valid;
    logic                      last_pair;

    modport source (output valid, stored_id, match_id, matched, pair_valid, last_pair,
                    input ready);
    modport sink   (input valid, stored_id, match_id, matched, pair_valid, last_pair,
                    output ready);
endinterface

`default_nettype wire

// ===== hdl/nmm_front.sv =====
// Front end: accepts request beats, decodes them into commands, queues them.
// Depends on nmm_pkg and nmm_req_if.
`default_nettype none

module nmm_front (
    input  logic          clk,
    input  logic          rst_n,
    nmm_req_if.sink       req,
    output logic          cmd_valid,
    input  logic          cmd_ready,
    output nmm_pkg::cmd_t cmd
);

    function automatic logic [nmm_pkg::COORD_BITS-1:0] coord_of(
        input logic [nmm_pkg::POS_W-1:0] v
    );
        logic [nmm_pkg::COORD_BITS-1:0] r;
        r = '0;
        for (int b = 0; b < nmm_pkg::COORD_BITS; b++)
        begin
            if (b < nmm_pkg::POS_W)
            begin
                r[b] = v[b];
            end
        end
        return r;
    endfunction

    nmm_pkg::cmd_t                q_mem [nmm_pkg::QUEUE_DEPTH];
    logic [nmm_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [nmm_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [nmm_pkg::QCNT_W-1:0]   q_cnt_reg;
    logic [nmm_pkg::QPTR_W-1:0]   wr_ptr_next;
    logic [nmm_pkg::QPTR_W-1:0]   rd_ptr_next;
    logic [nmm_pkg::QCNT_W-1:0]   q_cnt_next;
    logic                         push;
    logic                         pop;
    nmm_pkg::op_t                 op_dec;
    nmm_pkg::cmd_t                cmd_in;

    // every 2-bit code is a defined operation
    always_comb
    begin
        op_dec = nmm_pkg::op_t'(req.req_type);
    end

    always_comb
    begin
        cmd_in.op = op_dec;
        cmd_in.id = req.marker_id;
        cmd_in.x  = coord_of(req.pos_x);
        cmd_in.y  = coord_of(req.pos_y);
        cmd_in.z  = coord_of(req.pos_z);
    end

    assign req.ready = (q_cnt_reg != nmm_pkg::QCNT_W'(nmm_pkg::QUEUE_DEPTH));
    assign cmd_valid = (q_cnt_reg != '0);
    assign cmd       = q_mem[rd_ptr_reg];
    assign push      = req.valid && req.ready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        q_cnt_next  = q_cnt_reg + nmm_pkg::QCNT_W'(push) - nmm_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            q_cnt_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            q_cnt_reg  <= q_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/nmm_back.sv =====
// Back end: reference tables, distance pipeline, match state and result register.
// Depends on nmm_pkg, nmm_res_if and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module nmm_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  nmm_pkg::cmd_t cmd,
    nmm_res_if.source     res
);

    typedef enum logic [4:0] {
        ST_IDLE     = 5'b00001,
        ST_MEAS     = 5'b00010,
        ST_DRAIN    = 5'b00100,
        ST_EMIT_RD  = 5'b01000,
        ST_EMIT_OUT = 5'b10000
    } state_t;

    function automatic logic [nmm_pkg::DIFF_W-1:0] abs_diff(
        input logic [nmm_pkg::COORD_BITS-1:0] a,
        input logic [nmm_pkg::COORD_BITS-1:0] b
    );
        logic [nmm_pkg::DIFF_W-1:0] d;
        d = {a[nmm_pkg::COORD_BITS-1], a} - {b[nmm_pkg::COORD_BITS-1], b};
        return d[nmm_pkg::DIFF_W-1] ? (~d + 1'b1) : d;
    endfunction

    // tables
    logic [nmm_pkg::ID_W-1:0]         id_mem  [nmm_pkg::MAX_REFS];
    logic [3*nmm_pkg::COORD_BITS-1:0] pos_mem [nmm_pkg::MAX_REFS];
    logic [nmm_pkg::DIST_W-1:0]       bd_mem  [nmm_pkg::MAX_REFS];
    logic [nmm_pkg::ID_W-1:0]         bid_mem [nmm_pkg::MAX_REFS];

    logic [nmm_pkg::ID_W-1:0]         id_rd_reg;
    logic [3*nmm_pkg::COORD_BITS-1:0] pos_rd_reg;
    logic [nmm_pkg::DIST_W-1:0]       bd_rd_reg;
    logic [nmm_pkg::ID_W-1:0]         bid_rd_reg;

    // control
    state_t                        state_reg;
    state_t                        state_next;
    logic [nmm_pkg::CNT_W-1:0]     cnt_reg;
    logic [nmm_pkg::CNT_W-1:0]     cnt_next;
    logic [nmm_pkg::IDX_W-1:0]     scan_reg;
    logic [nmm_pkg::IDX_W-1:0]     scan_next;
    logic [nmm_pkg::MAX_REFS-1:0]  seen_reg;
    logic [nmm_pkg::MAX_REFS-1:0]  seen_next;
    logic [3:0]                    pv_reg;
    logic [3:0]                    pv_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;

    logic                          out_free;
    logic                          out_load;
    logic                          ld_we;
    logic                          meas_start;
    logic                          issue;
    logic                          scan_last;
    logic                          upd;

    // measured marker
    logic [nmm_pkg::ID_W-1:0]        meas_id_reg;
    logic [nmm_pkg::COORD_BITS-1:0]  meas_x_reg;
    logic [nmm_pkg::COORD_BITS-1:0]  meas_y_reg;
    logic [nmm_pkg::COORD_BITS-1:0]  meas_z_reg;

    // distance pipeline
    logic [nmm_pkg::IDX_W-1:0]   s1_idx_reg;
    logic [nmm_pkg::DIFF_W-1:0]  s2_mx_reg;
    logic [nmm_pkg::DIFF_W-1:0]  s2_my_reg;
    logic [nmm_pkg::DIFF_W-1:0]  s2_mz_reg;
    logic [nmm_pkg::IDX_W-1:0]   s2_idx_reg;
    logic [nmm_pkg::DIST_W-1:0]  s2_bd_reg;
    logic [nmm_pkg::SQ_W-1:0]    s3_qx_reg;
    logic [nmm_pkg::SQ_W-1:0]    s3_qy_reg;
    logic [nmm_pkg::SQ_W-1:0]    s3_qz_reg;
    logic [nmm_pkg::IDX_W-1:0]   s3_idx_reg;
    logic [nmm_pkg::DIST_W-1:0]  s3_bd_reg;
    logic [nmm_pkg::DIST_W-1:0]  s4_dist_reg;
    logic [nmm_pkg::IDX_W-1:0]   s4_idx_reg;
    logic [nmm_pkg::DIST_W-1:0]  s4_bd_reg;
    logic [nmm_pkg::SUM_W-1:0]   sum3;
    logic [nmm_pkg::DIST_W-1:0]  sum_sat;

    // result register
    logic [nmm_pkg::ID_W-1:0]  stored_id_reg;
    logic [nmm_pkg::ID_W-1:0]  match_id_reg;
    logic                      matched_reg;
    logic                      pair_valid_reg;
    logic                      last_pair_reg;

    assign cmd_ready = (state_reg == ST_IDLE);
    assign out_free  = !out_valid_reg || res.ready;
    assign scan_last = (nmm_pkg::CNT_W'(scan_reg) + nmm_pkg::CNT_W'(1)) == cnt_reg;
    assign upd       = pv_reg[3] && (!seen_reg[s4_idx_reg] || (s4_dist_reg < s4_bd_reg));

    assign sum3    = nmm_pkg::SUM_W'(s3_qx_reg) + nmm_pkg::SUM_W'(s3_qy_reg)
                   + nmm_pkg::SUM_W'(s3_qz_reg);
    assign sum_sat = (sum3 > nmm_pkg::SUM_W'(nmm_pkg::DIST_MAX))
                   ? nmm_pkg::DIST_MAX : sum3[nmm_pkg::DIST_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        scan_next      = scan_reg;
        seen_next      = seen_reg;
        out_valid_next = out_valid_reg && !res.ready;
        out_load       = 1'b0;
        ld_we          = 1'b0;
        meas_start     = 1'b0;
        issue          = 1'b0;

        if (upd)
        begin
            seen_next[s4_idx_reg] = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (cmd.op)
                        nmm_pkg::OP_LOAD:
                        begin
                            if (cnt_reg < nmm_pkg::CNT_W'(nmm_pkg::MAX_REFS))
                            begin
                                ld_we = 1'b1;
                                seen_next[cnt_reg[nmm_pkg::IDX_W-1:0]] = 1'b0;
                                cnt_next = cnt_reg + 1'b1;
                            end
                        end
                        nmm_pkg::OP_MEASURE:
                        begin
                            if (cnt_reg != '0)
                            begin
                                meas_start = 1'b1;
                                scan_next  = '0;
                                state_next = ST_MEAS;
                            end
                        end
                        nmm_pkg::OP_EMIT:
                        begin
                            scan_next  = '0;
                            state_next = ST_EMIT_RD;
                        end
                        nmm_pkg::OP_CLEAR:
                        begin
                            cnt_next  = '0;
                            seen_next = '0;
                        end
                    endcase
                end
            end
            ST_MEAS:
            begin
                issue = 1'b1;
                if (scan_last)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (pv_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_OUT;
            end
            ST_EMIT_OUT:
            begin
                if (out_free)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    if (cnt_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        seen_next[scan_reg] = 1'b0;
                        if (scan_last)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            scan_next  = scan_reg + 1'b1;
                            state_next = ST_EMIT_RD;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        pv_next = {pv_reg[2:0], issue};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            scan_reg      <= '0;
            seen_reg      <= '0;
            pv_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            scan_reg      <= scan_next;
            seen_reg      <= seen_next;
            pv_reg        <= pv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // table writes addressed by the entry count, registered reads addressed by the scan index
    always_ff @(posedge clk)
    begin
        if (ld_we)
        begin
            id_mem[cnt_reg[nmm_pkg::IDX_W-1:0]]  <= cmd.id;
            pos_mem[cnt_reg[nmm_pkg::IDX_W-1:0]] <= {cmd.x, cmd.y, cmd.z};
        end
        id_rd_reg  <= id_mem[scan_reg];
        pos_rd_reg <= pos_mem[scan_reg];
    end

    always_ff @(posedge clk)
    begin
        if (upd)
        begin
            bd_mem[s4_idx_reg]  <= s4_dist_reg;
            bid_mem[s4_idx_reg] <= meas_id_reg;
        end
        bd_rd_reg  <= bd_mem[scan_reg];
        bid_rd_reg <= bid_mem[scan_reg];
    end

    always_ff @(posedge clk)
    begin
        if (meas_start)
        begin
            meas_id_reg <= cmd.id;
            meas_x_reg  <= cmd.x;
            meas_y_reg  <= cmd.y;
            meas_z_reg  <= cmd.z;
        end
    end

    // S1 read, S2 abs diff, S3 square, S4 sum and saturate, then compare/write
    always_ff @(posedge clk)
    begin
        s1_idx_reg  <= scan_reg;
        s2_mx_reg   <= abs_diff(meas_x_reg,
                                pos_rd_reg[3*nmm_pkg::COORD_BITS-1:2*nmm_pkg::COORD_BITS]);
        s2_my_reg   <= abs_diff(meas_y_reg,
                                pos_rd_reg[2*nmm_pkg::COORD_BITS-1:nmm_pkg::COORD_BITS]);
        s2_mz_reg   <= abs_diff(meas_z_reg, pos_rd_reg[nmm_pkg::COORD_BITS-1:0]);
        s2_idx_reg  <= s1_idx_reg;
        s2_bd_reg   <= bd_rd_reg;
        s3_qx_reg   <= s2_mx_reg * s2_mx_reg;
        s3_qy_reg   <= s2_my_reg * s2_my_reg;
        s3_qz_reg   <= s2_mz_reg * s2_mz_reg;
        s3_idx_reg  <= s2_idx_reg;
        s3_bd_reg   <= s2_bd_reg;
        s4_dist_reg <= sum_sat;
        s4_idx_reg  <= s3_idx_reg;
        s4_bd_reg   <= s3_bd_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            if (cnt_reg == '0)
            begin
                stored_id_reg  <= '0;
                match_id_reg   <= '0;
                matched_reg    <= 1'b0;
                pair_valid_reg <= 1'b0;
                last_pair_reg  <= 1'b1;
            end
            else
            begin
                stored_id_reg  <= id_rd_reg;
                match_id_reg   <= seen_reg[scan_reg] ? bid_rd_reg : '0;
                matched_reg    <= seen_reg[scan_reg];
                pair_valid_reg <= 1'b1;
                last_pair_reg  <= scan_last;
            end
        end
    end

    assign res.valid      = out_valid_reg;
    assign res.stored_id  = stored_id_reg;
    assign res.match_id   = match_id_reg;
    assign res.matched    = matched_reg;
    assign res.pair_valid = pair_valid_reg;
    assign res.last_pair  = last_pair_reg;

    `NMM_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_reg <= nmm_pkg::CNT_W'(nmm_pkg::MAX_REFS), "entry count above table size")
    `NMM_ASSERT_IMP(a_scan_bound, state_reg == ST_MEAS, nmm_pkg::CNT_W'(scan_reg) < cnt_reg, "scan index past stored entries")
    `NMM_ASSERT_IMP(a_pipe_busy, pv_reg != '0, state_reg == ST_MEAS || state_reg == ST_DRAIN, "distance pipeline active outside a measure")
    `NMM_ASSERT_NXT(a_seen_set, upd, seen_reg[$past(s4_idx_reg)], "match update did not mark entry")
    `NMM_ASSERT_IMP(a_empty_last, res.valid && !res.pair_valid, res.last_pair, "empty-table beat not marked last")

endmodule

`default_nettype wire

// ===== hdl/nearest_marker_matcher.sv =====
// Nearest marker matcher: a two-entry command queue separates the request port
// from the execution side. Load and clear complete there without leaving the
// idle state. A measure beat streams the stored entries through a single
// squared-distance pipeline, one entry per cycle, and holds the execution side
// from its accept until the pipeline has drained. An emit beat reads the
// entries one at a time, each through ST_EMIT_RD and ST_EMIT_OUT, into the
// result register, which holds a beat while the sink stalls; an empty table
// gives one beat with pair_valid low. Depends on nmm_pkg, the channel
// interfaces, nmm_front and nmm_back.
`default_nettype none

module nearest_marker_matcher (
    input  logic      clk,
    input  logic      rst_n,
    nmm_req_if.sink   req,
    nmm_res_if.source res
);

    logic          cmd_valid;
    logic          cmd_ready;
    nmm_pkg::cmd_t cmd;

    nmm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    nmm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res       (res)
    );

endmodule

`default_nettype wire
